// ----- rtl/core/skf_pkg.sv -----
// Shared constants and types for the scalar Kalman level filter core.
// No dependencies; used by scalar_kalman_level_filter_core.
`default_nettype none

package skf_pkg;

   // Sample / estimate width (signed, 16 fraction bits); legal range 16..64
   localparam int SAMPLE_WIDTH = 40;

   // Variance format: unsigned Q2.30
   localparam int VAR_W      = 32;
   localparam int FRAC_BITS  = 30;
   localparam int GAIN_W     = FRAC_BITS + 1;          // Q1.30 gain, value <= 1.0
   localparam int DIV_STEPS  = FRAC_BITS;              // radix-2 steps after the 1.0 bit
   localparam int CNT_W      = $clog2(DIV_STEPS);

   // Shared multiplier: 32 x 31
   localparam int MUL_A_W    = 32;
   localparam int MUL_P_W    = MUL_A_W + GAIN_W;

   // Innovation magnitude is multiplied in 32-bit chunks, high chunk first
   localparam int MAG_CHUNKS = (SAMPLE_WIDTH + MUL_A_W - 1) / MUL_A_W;
   localparam int MAG_PAD_W  = MAG_CHUNKS * MUL_A_W;
   localparam int CHUNK_W    = (MAG_CHUNKS > 1) ? $clog2(MAG_CHUNKS) : 1;
   localparam int PROD_W     = SAMPLE_WIDTH + GAIN_W;

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = VAR_W;
   localparam logic [CSR_INDEX_W-1:0] REG_PROCESS_VAR = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MEAS_VAR    = 4'd1;

   // Reset values
   localparam logic [VAR_W-1:0] PROCESS_VAR_RST = 32'd10737;     // about 1e-5
   localparam logic [VAR_W-1:0] MEAS_VAR_RST    = 32'd1073742;   // about 1e-3
   localparam logic [VAR_W-1:0] ONE_Q30         = 32'h4000_0000; // 1.0

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic        [SAMPLE_WIDTH-1:0] mag_type;
   typedef logic        [VAR_W-1:0]        var_type;
   typedef logic        [GAIN_W-1:0]       gain_type;

endpackage

`default_nettype wire

// ----- rtl/core/scalar_kalman_level_filter_core.sv -----
// Scalar local-level Kalman filter core: sequencer around one shared 32x31 multiplier
// and one radix-2 restoring divider step. Depends on skf_pkg.
//
// Usage:
//  - req_* channel: one beat carries a sample (signed, 16 fraction bits) and a
//    start_series flag, taken when req_valid is high and req_stall low.
//    start_series reloads the level from the sample and the variance with 1.0
//    before the predict/update step.
//  - rsp_* channel: one beat per request with the new estimate and error variance
//    (unsigned Q2.30). Taken when rsp_valid is high and rsp_stall low.
//  - csr_* channel: index 0 = process variance Q, index 1 = measurement variance R,
//    both Q2.30. csr_ready is always high; other indexes are dropped. Write only
//    while no request is in flight.
//  - Steps from request beat to rsp_valid: 30 gain division steps, a multiply and
//    an accumulate per 32-bit chunk of the innovation, and one pass for the variance.
//    req_stall stays high until the result is loaded, so a new sample waits until
//    the last one is through.
//  - A stalled result holds the output register; the following result waits in
//    the last step until the slot frees.
//  - Synchronous reset: level 0, variance 1.0, Q and R at defaults, no result.
`default_nettype none

module scalar_kalman_level_filter_core (
   input  wire                                   clock,
   input  wire                                   reset,
   // request channel
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  signed [skf_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  wire                                   req_start_series,
   // result channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [skf_pkg::SAMPLE_WIDTH-1:0] rsp_estimate,
   output logic        [skf_pkg::VAR_W-1:0]      rsp_error_variance,
   // configuration channel
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire         [skf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire         [skf_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int SW = skf_pkg::SAMPLE_WIDTH;
   localparam int FB = skf_pkg::FRAC_BITS;

   // sequencer codes
   localparam logic [2:0] ST_IDLE    = 3'd0;  // wait for a request beat
   localparam logic [2:0] ST_PRED    = 3'd1;  // Ppred = sat(P+Q), innovation
   localparam logic [2:0] ST_DIVINIT = 3'd2;  // divisor, integer gain bit
   localparam logic [2:0] ST_DIV     = 3'd3;  // one gain bit per cycle
   localparam logic [2:0] ST_MUL     = 3'd4;  // chunk of |z-x| times K
   localparam logic [2:0] ST_ACC     = 3'd5;  // accumulate chunk product
   localparam logic [2:0] ST_VMUL    = 3'd6;  // (1-K)*Ppred, level update
   localparam logic [2:0] ST_VUPD    = 3'd7;  // store variance, load result

   logic [2:0] state_ff, state_in;

   // configuration
   skf_pkg::var_type q_var_ff, q_var_in;
   skf_pkg::var_type r_var_ff, r_var_in;

   // filter state
   skf_pkg::sample_type x_ff, x_in;
   skf_pkg::var_type    p_ff, p_in;

   // per-item working registers
   skf_pkg::sample_type               z_ff, z_in;
   skf_pkg::var_type                  ppred_ff, ppred_in;
   skf_pkg::mag_type                  mag_ff, mag_in;
   logic                              neg_ff, neg_in;
   logic [skf_pkg::VAR_W:0]           div_ff, div_in;
   logic                              div_zero_ff, div_zero_in;
   logic [skf_pkg::VAR_W:0]           rem_ff, rem_in;
   skf_pkg::gain_type                 k_ff, k_in;
   logic [skf_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [skf_pkg::CHUNK_W-1:0]       chunk_ff, chunk_in;
   logic [skf_pkg::MUL_P_W-1:0]       prod_ff, prod_in;
   logic [skf_pkg::PROD_W-1:0]        acc_ff, acc_in;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   skf_pkg::sample_type               rsp_est_ff, rsp_est_in;
   skf_pkg::var_type                  rsp_var_ff, rsp_var_in;

   // combinational helpers
   logic                              req_take;
   logic                              rsp_free;
   logic [skf_pkg::VAR_W:0]           p_sum;
   logic signed [SW:0]                diff;
   logic [skf_pkg::VAR_W:0]           div_new;
   logic [skf_pkg::VAR_W+1:0]         rem_dbl;
   logic [skf_pkg::VAR_W+1:0]         rem_sub;
   logic                              rem_ge;
   skf_pkg::gain_type                 k_shift;
   logic [skf_pkg::MAG_PAD_W-1:0]     mag_pad;
   logic [skf_pkg::MUL_A_W-1:0]       mul_a;
   skf_pkg::gain_type                 mul_b;
   logic [skf_pkg::MUL_P_W-1:0]       mul_p;
   skf_pkg::mag_type                  q_step;
   logic                              q_rem;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_estimate       = rsp_est_ff;
   assign rsp_error_variance = rsp_var_ff;

   // datapath pieces shared by the sequencer
   assign p_sum   = {1'b0, p_ff} + {1'b0, q_var_ff};
   assign diff    = {z_ff[SW-1], z_ff} - {x_ff[SW-1], x_ff};
   assign div_new = {1'b0, ppred_ff} + {1'b0, r_var_ff};
   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_sub = rem_dbl - {1'b0, div_ff};
   assign rem_ge  = (rem_dbl >= {1'b0, div_ff});
   assign k_shift = {k_ff[skf_pkg::GAIN_W-2:0], rem_ge};
   assign mag_pad = skf_pkg::MAG_PAD_W'(mag_ff);
   assign q_step  = SW'(acc_ff >> FB);
   assign q_rem   = |acc_ff[FB-1:0];

   // one shared multiplier: innovation chunks times K, then Ppred times (1-K)
   always_comb begin
      if (state_ff == ST_VMUL) begin
         mul_a = ppred_ff;
         mul_b = skf_pkg::GAIN_W'(skf_pkg::ONE_Q30) - k_ff;
      end else begin
         mul_a = mag_pad[chunk_ff*skf_pkg::MUL_A_W +: skf_pkg::MUL_A_W];
         mul_b = k_ff;
      end
      mul_p = skf_pkg::MUL_P_W'(mul_a) * skf_pkg::MUL_P_W'(mul_b);
   end

   always_comb begin
      state_in     = state_ff;
      q_var_in     = q_var_ff;
      r_var_in     = r_var_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      z_in         = z_ff;
      ppred_in     = ppred_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      div_in       = div_ff;
      div_zero_in  = div_zero_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      chunk_in     = chunk_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_est_in   = rsp_est_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            skf_pkg::REG_PROCESS_VAR: q_var_in = csr_data;
            skf_pkg::REG_MEAS_VAR:    r_var_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               z_in = req_sample;
               if (req_start_series) begin
                  x_in = req_sample;
                  p_in = skf_pkg::ONE_Q30;
               end
               state_in = ST_PRED;
            end
         end
         ST_PRED: begin
            // saturate P+Q at all ones
            ppred_in = p_sum[skf_pkg::VAR_W] ? '1 : p_sum[skf_pkg::VAR_W-1:0];
            neg_in   = diff[SW];
            mag_in   = diff[SW] ? SW'(-diff) : SW'(diff);
            state_in = ST_DIVINIT;
         end
         ST_DIVINIT: begin
            div_in      = div_new;
            div_zero_in = (div_new == '0);
            cnt_in      = '0;
            // Ppred/(Ppred+R) reaches 1.0 only when R is zero
            if (r_var_ff == '0) begin
               k_in   = skf_pkg::GAIN_W'(div_new != '0);
               rem_in = '0;
            end else begin
               k_in   = '0;
               rem_in = {1'b0, ppred_ff};
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // remainder stays below the divisor, which may need all 33 bits
            rem_in = rem_ge ? rem_sub[skf_pkg::VAR_W:0] : rem_dbl[skf_pkg::VAR_W:0];
            k_in   = k_shift;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
               if (div_zero_ff) begin
                  k_in = '0;
               end
               chunk_in = skf_pkg::CHUNK_W'(skf_pkg::MAG_CHUNKS - 1);
               acc_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mul_p;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = (acc_ff << skf_pkg::MUL_A_W) + skf_pkg::PROD_W'(prod_ff);
            if (chunk_ff == '0) begin
               state_in = ST_VMUL;
            end else begin
               chunk_in = chunk_ff - 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_VMUL: begin
            prod_in = mul_p;
            // floor shift: a negative step with a dropped remainder rounds away
            if (neg_ff) begin
               x_in = x_ff - $signed(q_step + SW'(q_rem));
            end else begin
               x_in = x_ff + $signed(q_step);
            end
            state_in = ST_VUPD;
         end
         ST_VUPD: begin
            if (rsp_free) begin
               p_in         = prod_ff[FB +: skf_pkg::VAR_W];
               rsp_est_in   = x_ff;
               rsp_var_in   = prod_ff[FB +: skf_pkg::VAR_W];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         q_var_ff     <= skf_pkg::PROCESS_VAR_RST;
         r_var_ff     <= skf_pkg::MEAS_VAR_RST;
         x_ff         <= '0;
         p_ff         <= skf_pkg::ONE_Q30;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_var_ff     <= q_var_in;
         r_var_ff     <= r_var_in;
         x_ff         <= x_in;
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff        <= z_in;
      ppred_ff    <= ppred_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      div_ff      <= div_in;
      div_zero_ff <= div_zero_in;
      rem_ff      <= rem_in;
      k_ff        <= k_in;
      cnt_ff      <= cnt_in;
      chunk_ff    <= chunk_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_var_ff  <= rsp_var_in;
   end

endmodule

`default_nettype wire
